// ===== rtl/core/escaped_frame_receiver_top_macros.svh =====
// ---------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication.
`define EFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("efr assertion failed");

// Next-cycle implication.
`define EFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("efr assertion failed");

`endif

// ===== rtl/core/efr_pkg.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver package
// Types, register map and reset values shared by the receiver modules.
// ---------------------------------------------------------------------------
package efr_pkg;

	localparam int unsigned CfgAddrWidth = 5;
	localparam int unsigned CfgDataWidth = 32;

	typedef enum logic [2:0] {
		REG_START_BYTE     = 3'd0,
		REG_END_BYTE       = 3'd1,
		REG_ESCAPE_BYTE    = 3'd2,
		REG_ESC_START_CODE = 3'd3,
		REG_ESC_END_CODE   = 3'd4,
		REG_ESC_ESC_CODE   = 3'd5,
		REG_PACKET_TYPE    = 3'd6,
		REG_PAYLOAD_LENGTH = 3'd7
	} reg_index_t;

	localparam logic [7:0] START_BYTE_RST     = 8'd192;
	localparam logic [7:0] END_BYTE_RST       = 8'd193;
	localparam logic [7:0] ESCAPE_BYTE_RST    = 8'd219;
	localparam logic [7:0] ESC_START_CODE_RST = 8'd220;
	localparam logic [7:0] ESC_END_CODE_RST   = 8'd221;
	localparam logic [7:0] ESC_ESC_CODE_RST   = 8'd222;
	localparam logic [7:0] PACKET_TYPE_RST    = 8'd1;
	localparam logic [7:0] PAYLOAD_LENGTH_RST = 8'd64;

	typedef enum logic {
		OP_BYTE    = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_RECEIVING = 2'd1,
		ST_COMPLETE  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] escape_byte;
		logic [7:0] escaped_start_code;
		logic [7:0] escaped_end_code;
		logic [7:0] escaped_escape_code;
		logic [7:0] packet_type;
		logic [7:0] payload_length;
	} cfg_t;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] write_offset;
		logic [7:0] write_data;
		status_t    frame_status;
	} result_t;

endpackage

// ===== rtl/core/efr_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver configuration registers
// APB-style register file holding the framing bytes, type and length.
// ---------------------------------------------------------------------------
module efr_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [efr_pkg::CfgAddrWidth-1:0]    paddr,
	input  logic [efr_pkg::CfgDataWidth-1:0]    pwdata,
	output logic [efr_pkg::CfgDataWidth-1:0]    prdata,
	output logic                                pready,
	output efr_pkg::cfg_t                       cfg
);
	import efr_pkg::*;

	cfg_t       cfg_q;
	reg_index_t sel;
	logic       wr_en;
	logic [7:0] rd_byte;

	assign sel    = reg_index_t'(paddr[CfgAddrWidth-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte          <= START_BYTE_RST;
			cfg_q.end_byte            <= END_BYTE_RST;
			cfg_q.escape_byte         <= ESCAPE_BYTE_RST;
			cfg_q.escaped_start_code  <= ESC_START_CODE_RST;
			cfg_q.escaped_end_code    <= ESC_END_CODE_RST;
			cfg_q.escaped_escape_code <= ESC_ESC_CODE_RST;
			cfg_q.packet_type         <= PACKET_TYPE_RST;
			cfg_q.payload_length      <= PAYLOAD_LENGTH_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_START_BYTE:     cfg_q.start_byte          <= pwdata[7:0];
				REG_END_BYTE:       cfg_q.end_byte            <= pwdata[7:0];
				REG_ESCAPE_BYTE:    cfg_q.escape_byte         <= pwdata[7:0];
				REG_ESC_START_CODE: cfg_q.escaped_start_code  <= pwdata[7:0];
				REG_ESC_END_CODE:   cfg_q.escaped_end_code    <= pwdata[7:0];
				REG_ESC_ESC_CODE:   cfg_q.escaped_escape_code <= pwdata[7:0];
				REG_PACKET_TYPE:    cfg_q.packet_type         <= pwdata[7:0];
				REG_PAYLOAD_LENGTH: cfg_q.payload_length      <= pwdata[7:0];
				default:            cfg_q.start_byte          <= cfg_q.start_byte;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_START_BYTE:     rd_byte = cfg_q.start_byte;
			REG_END_BYTE:       rd_byte = cfg_q.end_byte;
			REG_ESCAPE_BYTE:    rd_byte = cfg_q.escape_byte;
			REG_ESC_START_CODE: rd_byte = cfg_q.escaped_start_code;
			REG_ESC_END_CODE:   rd_byte = cfg_q.escaped_end_code;
			REG_ESC_ESC_CODE:   rd_byte = cfg_q.escaped_escape_code;
			REG_PACKET_TYPE:    rd_byte = cfg_q.packet_type;
			REG_PAYLOAD_LENGTH: rd_byte = cfg_q.payload_length;
			default:            rd_byte = 8'd0;
		endcase
	end

	assign prdata = {{(CfgDataWidth-8){1'b0}}, rd_byte};

endmodule

// ===== rtl/core/efr_deframe.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver deframing core
// Frame state registers and the per-byte decode of start, end and escapes.
// ---------------------------------------------------------------------------
`include "escaped_frame_receiver_top_macros.svh"

module efr_deframe (
	input  logic             clk,
	input  logic             arst_n,
	input  efr_pkg::cfg_t    cfg,
	input  logic             step,
	input  efr_pkg::op_t     operation,
	input  logic [7:0]       rx_byte,
	output efr_pkg::result_t result
);
	import efr_pkg::*;

	status_t    status_q;
	status_t    status_d;
	logic [7:0] position_q;
	logic [7:0] position_d;
	logic       escape_q;
	logic       escape_d;
	logic [8:0] size_sum;
	logic [7:0] frame_size;
	logic [7:0] data_b;
	logic       code_ok;

	assign size_sum   = {1'b0, cfg.payload_length} + 9'd1;
	assign frame_size = size_sum[8] ? 8'hFF : size_sum[7:0];

	always_comb begin
		code_ok = 1'b1;
		priority if (!escape_q) begin
			data_b = rx_byte;
		end else if (rx_byte == cfg.escaped_start_code) begin
			data_b = cfg.start_byte;
		end else if (rx_byte == cfg.escaped_end_code) begin
			data_b = cfg.end_byte;
		end else if (rx_byte == cfg.escaped_escape_code) begin
			data_b = cfg.escape_byte;
		end else begin
			data_b  = rx_byte;
			code_ok = 1'b0;
		end
	end

	always_comb begin
		status_d   = status_q;
		position_d = position_q;
		escape_d   = escape_q;
		result     = '0;
		if (step) begin
			unique case (operation)
				OP_RELEASE: begin
					if (status_q == ST_COMPLETE) begin
						status_d = ST_IDLE;
					end
				end
				OP_BYTE: begin
					if (status_q != ST_COMPLETE) begin
						priority if (rx_byte == cfg.start_byte) begin
							status_d   = ST_RECEIVING;
							position_d = 8'd0;
							escape_d   = 1'b0;
						end else if (rx_byte == cfg.end_byte) begin
							status_d = (position_q == frame_size) ? ST_COMPLETE : ST_IDLE;
						end else if (rx_byte == cfg.escape_byte) begin
							escape_d = 1'b1;
						end else if (position_q >= frame_size) begin
							status_d = ST_IDLE;
						end else if (!code_ok) begin
							status_d = ST_IDLE;
							escape_d = 1'b0;
						end else begin
							escape_d = 1'b0;
							if (position_q == 8'd0) begin
								if (data_b != cfg.packet_type) begin
									status_d = ST_IDLE;
								end else begin
									position_d = position_q + 8'd1;
								end
							end else begin
								result.write_valid  = 1'b1;
								result.write_offset = position_q - 8'd1;
								result.write_data   = data_b;
								position_d          = position_q + 8'd1;
							end
						end
					end
				end
				default: status_d = status_q;
			endcase
		end
		result.frame_status = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= ST_IDLE;
			position_q <= 8'd0;
			escape_q   <= 1'b0;
		end else begin
			status_q   <= status_d;
			position_q <= position_d;
			escape_q   <= escape_d;
		end
	end

	`EFR_ASSERT_IMP(a_write_needs_open_frame, step && result.write_valid,
		position_q != 8'd0 && status_q != ST_COMPLETE)
	`EFR_ASSERT_NXT(a_complete_frame_holds,
		step && operation == OP_BYTE && status_q == ST_COMPLETE,
		status_q == ST_COMPLETE && $stable(position_q) && $stable(escape_q))
	`EFR_ASSERT_NXT(a_start_byte_rewinds,
		step && operation == OP_BYTE && status_q != ST_COMPLETE && rx_byte == cfg.start_byte,
		position_q == 8'd0 && !escape_q && status_q == ST_RECEIVING)

endmodule

// ===== rtl/core/escaped_frame_receiver_top.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed packet deframer with stream input, stream output and APB port.
// ---------------------------------------------------------------------------
// The slave stream carries one item per transfer: a received line byte in
// tdata, or a release command when tuser is set. Every accepted item gives
// exactly one result transfer on the master stream, in order. The result says
// whether a payload byte was stored, its offset and unescaped value, and the
// frame status after the item.
// An accepted item sits in the input register, is decoded against the frame
// state there, and its result is then held in the output register, from which
// it shows on the master stream. One item is taken every cycle while the
// output side keeps up.
// When the master side stalls, the result stays put, the input register
// still holds one more item, and tready drops only when both are full.
// Reset clears the frame state to idle, empties both registers and loads the
// default framing bytes, type 1 and a payload length of 64. The user must
// write the APB port only while no item is in flight; no logic enforces it.
// ---------------------------------------------------------------------------
`include "escaped_frame_receiver_top_macros.svh"

module escaped_frame_receiver_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [efr_pkg::CfgAddrWidth-1:0]  paddr,
	input  logic [efr_pkg::CfgDataWidth-1:0]  pwdata,
	output logic [efr_pkg::CfgDataWidth-1:0]  prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
	input  logic [0:0]                        s_axis_tuser,  // [0] operation
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] write_offset, [15:8] write_data, [17:16] frame_status, rest zero
	output logic [23:0]                       m_axis_tdata,
	output logic [0:0]                        m_axis_tuser   // [0] write_valid
);
	import efr_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	result_t    result;
	logic       out_valid_q;
	result_t    out_q;

	efr_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= op_t'(s_axis_tuser[0]);
			byte_s1 <= s_axis_tdata;
		end
	end

	efr_deframe u_deframe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.operation (op_s1),
		.rx_byte   (byte_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.write_valid;
	assign m_axis_tdata  = {6'd0, out_q.frame_status, out_q.write_data, out_q.write_offset};

	`EFR_ASSERT_NXT(a_stalled_input_kept, valid_s1 && !advance, valid_s1)
	`EFR_ASSERT_IMP(a_ready_low_only_when_full, !s_axis_tready, valid_s1 && out_valid_q)
	`EFR_ASSERT_IMP(a_no_write_zero_fields, out_valid_q && !out_q.write_valid,
		out_q.write_offset == 8'd0 && out_q.write_data == 8'd0)

endmodule

// ===== bench/escaped_frame_receiver_top_tb.sv =====
// ---------------------------------------------------------------------------
// Escaped frame receiver testbench
// Drives byte and release items into the slave stream and predicts each
// result transfer from a private copy of the frame state and registers.
// Directed frames cover escapes, framing errors and overlapping framing
// values. Random phases then send well-formed and damaged frames under
// random register settings, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module escaped_frame_receiver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import efr_pkg::*;

	typedef enum int {
		FLAW_NONE,
		FLAW_SHORT,
		FLAW_LONG,
		FLAW_BAD_TYPE,
		FLAW_BAD_ESCAPE,
		FLAW_NO_RELEASE
	} frame_flaw_t;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS   = 180;
	localparam logic [8:0]  RELEASE_ITEM   = {OP_RELEASE, 8'h00};
	localparam cfg_t        RESET_CFG      = '{START_BYTE_RST, END_BYTE_RST, ESCAPE_BYTE_RST,
		ESC_START_CODE_RST, ESC_END_CODE_RST, ESC_ESC_CODE_RST, PACKET_TYPE_RST,
		PAYLOAD_LENGTH_RST};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [CfgAddrWidth-1:0] paddr = '0;
	logic [CfgDataWidth-1:0] pwdata = '0;
	logic [CfgDataWidth-1:0] prdata;
	logic                    pready;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [7:0]              s_axis_tdata = '0;   // [7:0] rx_byte
	logic [0:0]              s_axis_tuser = '0;   // [0] operation
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [23:0]             m_axis_tdata;        // [7:0] offset, [15:8] data, [17:16] status
	logic [0:0]              m_axis_tuser;        // [0] write_valid

	cfg_t        rx_cfg;
	status_t     rx_status;
	logic [7:0]  rx_position;
	logic        rx_escape_armed;
	result_t     expected_results[$];
	logic [8:0]  byte_script[$];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned idle_cycles = 0;
	bit          sender_no_gaps = 1'b0;
	bit          receiver_no_stalls = 1'b0;

	escaped_frame_receiver_top i_dut (.*);

	always #1 clk = ~clk;

	function automatic result_t decode_rx_item(op_t op, logic [7:0] rx_byte);
		result_t    r;
		logic [8:0] frame_size;
		logic [7:0] value;
		bit         keep;
		r = '0;
		value = rx_byte;
		keep = 1'b1;
		frame_size = {1'b0, rx_cfg.payload_length} + 9'd1;
		if (frame_size > 9'd255) begin
			frame_size = 9'd255;
		end
		if (op == OP_RELEASE) begin
			if (rx_status == ST_COMPLETE) begin
				rx_status = ST_IDLE;
			end
		end else if (rx_status == ST_IDLE || rx_status == ST_RECEIVING) begin
			if (value == rx_cfg.start_byte) begin
				rx_status = ST_RECEIVING;
				rx_position = 8'd0;
				rx_escape_armed = 1'b0;
			end else if (value == rx_cfg.end_byte) begin
				rx_status = ({1'b0, rx_position} == frame_size) ? ST_COMPLETE : ST_IDLE;
			end else if (value == rx_cfg.escape_byte) begin
				rx_escape_armed = 1'b1;
			end else if ({1'b0, rx_position} >= frame_size) begin
				rx_status = ST_IDLE;
			end else begin
				if (rx_escape_armed) begin
					rx_escape_armed = 1'b0;
					if (value == rx_cfg.escaped_start_code) begin
						value = rx_cfg.start_byte;
					end else if (value == rx_cfg.escaped_end_code) begin
						value = rx_cfg.end_byte;
					end else if (value == rx_cfg.escaped_escape_code) begin
						value = rx_cfg.escape_byte;
					end else begin
						rx_status = ST_IDLE;
						keep = 1'b0;
					end
				end
				if (keep) begin
					if (rx_position == 8'd0) begin
						if (value != rx_cfg.packet_type) begin
							rx_status = ST_IDLE;
						end else begin
							rx_position = rx_position + 8'd1;
						end
					end else begin
						r.write_valid = 1'b1;
						r.write_offset = rx_position - 8'd1;
						r.write_data = value;
						rx_position = rx_position + 8'd1;
					end
				end
			end
		end
		r.frame_status = rx_status;
		return r;
	endfunction

	task automatic send_item(op_t op, logic [7:0] value);
		int unsigned gap;
		gap = sender_no_gaps ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(decode_rx_item(op, value));
		bytes_sent++;
	endtask

	task automatic play_script();
		foreach (byte_script[k]) begin
			send_item(op_t'(byte_script[k][8]), byte_script[k][7:0]);
		end
		byte_script.delete();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CfgAddrWidth'({idx, 2'b00});
		pwdata <= CfgDataWidth'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_START_BYTE:     rx_cfg.start_byte = value;
			REG_END_BYTE:       rx_cfg.end_byte = value;
			REG_ESCAPE_BYTE:    rx_cfg.escape_byte = value;
			REG_ESC_START_CODE: rx_cfg.escaped_start_code = value;
			REG_ESC_END_CODE:   rx_cfg.escaped_end_code = value;
			REG_ESC_ESC_CODE:   rx_cfg.escaped_escape_code = value;
			REG_PACKET_TYPE:    rx_cfg.packet_type = value;
			REG_PAYLOAD_LENGTH: rx_cfg.payload_length = value;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all_regs(cfg_t c);
		wait_idle();
		write_reg(REG_START_BYTE, c.start_byte);
		write_reg(REG_END_BYTE, c.end_byte);
		write_reg(REG_ESCAPE_BYTE, c.escape_byte);
		write_reg(REG_ESC_START_CODE, c.escaped_start_code);
		write_reg(REG_ESC_END_CODE, c.escaped_end_code);
		write_reg(REG_ESC_ESC_CODE, c.escaped_escape_code);
		write_reg(REG_PACKET_TYPE, c.packet_type);
		write_reg(REG_PAYLOAD_LENGTH, c.payload_length);
	endtask

	function automatic logic [7:0] pick_payload();
		case ($urandom_range(0, 7))
			0:       return rx_cfg.start_byte;
			1:       return rx_cfg.end_byte;
			2:       return rx_cfg.escape_byte;
			3:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_payload_byte(logic [7:0] value);
		if (value == rx_cfg.start_byte) begin
			send_item(OP_BYTE, rx_cfg.escape_byte);
			send_item(OP_BYTE, rx_cfg.escaped_start_code);
		end else if (value == rx_cfg.end_byte) begin
			send_item(OP_BYTE, rx_cfg.escape_byte);
			send_item(OP_BYTE, rx_cfg.escaped_end_code);
		end else if (value == rx_cfg.escape_byte) begin
			send_item(OP_BYTE, rx_cfg.escape_byte);
			send_item(OP_BYTE, rx_cfg.escaped_escape_code);
		end else begin
			send_item(OP_BYTE, value);
		end
	endtask

	task automatic send_frame(frame_flaw_t flaw);
		int unsigned count;
		int unsigned bad_at;
		logic [7:0]  code;
		count = (rx_cfg.payload_length == 8'd255) ? 254 : rx_cfg.payload_length;
		if (flaw == FLAW_SHORT && count != 0) begin
			count--;
		end
		if (flaw == FLAW_LONG) begin
			count++;
		end
		bad_at = $urandom_range(0, count);
		send_item(OP_BYTE, rx_cfg.start_byte);
		if (flaw == FLAW_BAD_TYPE) begin
			send_payload_byte(rx_cfg.packet_type ^ 8'($urandom_range(1, 255)));
		end else begin
			send_payload_byte(rx_cfg.packet_type);
		end
		for (int unsigned k = 0; k <= count; k++) begin
			if (flaw == FLAW_BAD_ESCAPE && k == bad_at) begin
				do begin
					code = 8'($urandom_range(0, 255));
				end while (code == rx_cfg.start_byte || code == rx_cfg.end_byte ||
					code == rx_cfg.escape_byte || code == rx_cfg.escaped_start_code ||
					code == rx_cfg.escaped_end_code || code == rx_cfg.escaped_escape_code);
				send_item(OP_BYTE, rx_cfg.escape_byte);
				send_item(OP_BYTE, code);
			end
			if (k < count) begin
				send_payload_byte(pick_payload());
			end
		end
		send_item(OP_BYTE, rx_cfg.end_byte);
		if (flaw != FLAW_NO_RELEASE) begin
			send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_noise(int unsigned count);
		repeat (count) begin
			send_item($urandom_range(0, 3) == 0 ? OP_RELEASE : OP_BYTE,
				8'($urandom_range(0, 255)));
		end
	endtask

	task automatic randomize_config(bit distinct);
		cfg_t        c;
		logic [7:0]  v[6];
		bit          clash;
		for (int i = 0; i < 6; i++) begin
			do begin
				v[i] = distinct ? 8'($urandom_range(0, 255)) : 8'hF0 + 8'($urandom_range(0, 2));
				clash = 1'b0;
				for (int j = 0; j < i; j++) begin
					if (distinct && v[j] == v[i]) begin
						clash = 1'b1;
					end
				end
			end while (clash);
		end
		c = '{v[0], v[1], v[2], v[3], v[4], v[5], 8'($urandom_range(0, 255)), 8'h00};
		c.payload_length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 255)) :
			8'($urandom_range(0, 12));
		write_all_regs(c);
	endtask

	task automatic test_directed_frames();
		wait_idle();
		write_reg(REG_PAYLOAD_LENGTH, 8'd3);
		byte_script = '{RELEASE_ITEM, 9'h001,
			9'h0C0, 9'h001, 9'h0DB, 9'h0DC, 9'h0DB, 9'h0DD, 9'h0DB, 9'h0DE, 9'h0C1,
			9'h055, RELEASE_ITEM, RELEASE_ITEM,
			9'h0C0, 9'h007,
			9'h0C0, 9'h001, 9'h0DB, 9'h000,
			9'h0C0, 9'h001, 9'h0DB, 9'h0C0, 9'h001, 9'h0DB, 9'h0DB, 9'h0DD, 9'h0FF, 9'h000,
			9'h010, 9'h0C1, RELEASE_ITEM,
			9'h0C0, 9'h001, 9'h0AA, 9'h0C1};
		play_script();
	endtask

	task automatic test_coinciding_framing();
		write_all_regs('{8'h5A, 8'h5A, 8'h5A, 8'h11, 8'h11, 8'h11, 8'h11, 8'd1});
		byte_script = '{9'h05A, 9'h011, 9'h022, 9'h05A, 9'h011, 9'h05A};
		play_script();
		write_all_regs('{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h80, 8'h80, 8'h00, 8'd2});
		byte_script = '{9'h000, 9'h07F, 9'h080, 9'h07F, 9'h07F, 9'h080, 9'h001, 9'h07F,
			9'h0FF, 9'h033, RELEASE_ITEM, 9'h07F, 9'h000, 9'h080};
		play_script();
	endtask

	task automatic test_length_extremes();
		cfg_t c;
		c = RESET_CFG;
		c.packet_type = 8'hFF;
		c.payload_length = 8'd0;
		write_all_regs(c);
		byte_script = '{9'h0C0, 9'h0FF, 9'h0C1, RELEASE_ITEM, 9'h0C0, 9'h0FF, 9'h000, 9'h0C1,
			RELEASE_ITEM};
		play_script();
		c.packet_type = 8'h00;
		c.payload_length = 8'd255;
		write_all_regs(c);
		send_frame(FLAW_NONE);
		c.payload_length = 8'd1;
		write_all_regs(c);
		send_frame(FLAW_NONE);
		send_frame(FLAW_SHORT);
	endtask

	task automatic test_default_config();
		write_all_regs(RESET_CFG);
		send_frame(FLAW_NONE);
		send_noise(6);
	endtask

	task automatic test_random_frames();
		int unsigned target;
		int unsigned phase_end;
		int unsigned pick;
		target = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < target) begin
			randomize_config($urandom_range(0, 4) != 0);
			sender_no_gaps = ($urandom_range(0, 3) == 0);
			receiver_no_stalls = ($urandom_range(0, 3) == 0);
			phase_end = bytes_sent + $urandom_range(40, 120);
			while (bytes_sent < phase_end && bytes_sent < target) begin
				pick = $urandom_range(0, 15);
				case (pick)
					8:       send_frame(FLAW_SHORT);
					9:       send_frame(FLAW_LONG);
					10:      send_frame(FLAW_BAD_TYPE);
					11:      send_frame(FLAW_BAD_ESCAPE);
					12:      send_frame(FLAW_NO_RELEASE);
					13, 14,
					15:      send_noise($urandom_range(1, 6));
					default: send_frame(FLAW_NONE);
				endcase
			end
		end
		sender_no_gaps = 1'b0;
		receiver_no_stalls = 1'b0;
	endtask

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	initial begin
		int unsigned gap;
		result_t     want;
		forever begin
			gap = receiver_no_stalls ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer with nothing expected, actual %h/%h", $time,
					m_axis_tuser, m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				compare_field("write_valid", 8'(want.write_valid), 8'(m_axis_tuser[0]));
				compare_field("write_offset", want.write_offset, m_axis_tdata[7:0]);
				compare_field("write_data", want.write_data, m_axis_tdata[15:8]);
				compare_field("frame_status", 8'(want.frame_status), 8'(m_axis_tdata[17:16]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		rx_cfg = RESET_CFG;
		rx_status = ST_IDLE;
		rx_position = 8'd0;
		rx_escape_armed = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_frames();
		test_coinciding_framing();
		test_length_extremes();
		test_default_config();
		test_random_frames();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== escaped_frame_receiver_top.f =====
+incdir+rtl/core
rtl/core/efr_pkg.sv
rtl/core/efr_cfg_regs.sv
rtl/core/efr_deframe.sv
rtl/core/escaped_frame_receiver_top.sv
bench/escaped_frame_receiver_top_tb.sv
